/* hdl/lmls_pkg.sv */
// Shared types, opcodes and decode for the linear memory load/store unit.
package lmls_pkg;

    localparam int unsigned PAGE_BYTES_DEF = 65536;
    localparam int unsigned MAX_PAGES_DEF  = 1;
    localparam int unsigned LANES          = 8;

    typedef enum logic [4:0] {
        CMD_LD_W32   = 5'd0,
        CMD_LD_D64   = 5'd1,
        CMD_LD_F32   = 5'd2,
        CMD_LD_F64   = 5'd3,
        CMD_LD_B_S32 = 5'd4,
        CMD_LD_B_U32 = 5'd5,
        CMD_LD_H_S32 = 5'd6,
        CMD_LD_H_U32 = 5'd7,
        CMD_LD_B_S64 = 5'd8,
        CMD_LD_B_U64 = 5'd9,
        CMD_LD_H_S64 = 5'd10,
        CMD_LD_H_U64 = 5'd11,
        CMD_LD_W_S64 = 5'd12,
        CMD_LD_W_U64 = 5'd13,
        CMD_ST_W32   = 5'd14,
        CMD_ST_D64   = 5'd15,
        CMD_ST_F32   = 5'd16,
        CMD_ST_F64   = 5'd17,
        CMD_ST_B32   = 5'd18,
        CMD_ST_H32   = 5'd19,
        CMD_ST_B64   = 5'd20,
        CMD_ST_H64   = 5'd21,
        CMD_ST_W64   = 5'd22,
        CMD_MEM_SIZE = 5'd23,
        CMD_MEM_GROW = 5'd24
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRAP  = 2'd1,
        ST_UNSUP = 2'd2
    } status_t;

    // size_log: access width is 1 << size_log bytes
    typedef struct packed {
        logic       is_load;
        logic       is_store;
        logic       is_size;
        logic [1:0] size_log;
        logic       sext;
        logic       wide;
    } access_t;

    function automatic access_t decode(input logic [4:0] op);
        access_t a;
        a = '0;
        case (opcode_t'(op))
            CMD_LD_W32, CMD_LD_F32:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd2;
            end
            CMD_LD_D64, CMD_LD_F64:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd3;
                a.wide     = 1'b1;
            end
            CMD_LD_B_S32:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd0;
                a.sext     = 1'b1;
            end
            CMD_LD_B_U32:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd0;
            end
            CMD_LD_H_S32:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd1;
                a.sext     = 1'b1;
            end
            CMD_LD_H_U32:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd1;
            end
            CMD_LD_B_S64:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd0;
                a.sext     = 1'b1;
                a.wide     = 1'b1;
            end
            CMD_LD_B_U64:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd0;
                a.wide     = 1'b1;
            end
            CMD_LD_H_S64:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd1;
                a.sext     = 1'b1;
                a.wide     = 1'b1;
            end
            CMD_LD_H_U64:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd1;
                a.wide     = 1'b1;
            end
            CMD_LD_W_S64:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd2;
                a.sext     = 1'b1;
                a.wide     = 1'b1;
            end
            CMD_LD_W_U64:
            begin
                a.is_load  = 1'b1;
                a.size_log = 2'd2;
                a.wide     = 1'b1;
            end
            CMD_ST_W32, CMD_ST_F32, CMD_ST_W64:
            begin
                a.is_store = 1'b1;
                a.size_log = 2'd2;
            end
            CMD_ST_D64, CMD_ST_F64:
            begin
                a.is_store = 1'b1;
                a.size_log = 2'd3;
            end
            CMD_ST_B32, CMD_ST_B64:
            begin
                a.is_store = 1'b1;
                a.size_log = 2'd0;
            end
            CMD_ST_H32, CMD_ST_H64:
            begin
                a.is_store = 1'b1;
                a.size_log = 2'd1;
            end
            CMD_MEM_SIZE:
            begin
                a.is_size = 1'b1;
            end
            default:
            begin
                a = '0;
            end
        endcase
        return a;
    endfunction

endpackage

/* hdl/lmls_bank.sv */
// One byte lane of the store: single-port synchronous RAM with registered read data.
module lmls_bank #(
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/linear_memory_load_store_unit_core.sv */
// An accepted word is held in the stage-1 registers, then in the output register.
// Throughput: one word per cycle while rsp_stall is low; eight byte-lane RAMs serve any
// access of up to eight bytes, aligned or not, with one read or write per lane per cycle.
// A load right after a store sees the stored bytes.
// Reset clears the pipeline valid flags and sets pages_reg to one page;
// the byte store is not cleared and holds undefined bytes until written.
module linear_memory_load_store_unit_core #(
    parameter int unsigned PAGE_BYTES = lmls_pkg::PAGE_BYTES_DEF,
    parameter int unsigned MAX_PAGES  = lmls_pkg::MAX_PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [4:0]  opcode,
    input  logic [31:0] base_address,
    input  logic [31:0] address_offset,
    input  logic [63:0] store_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [63:0] result_value,
    output logic [1:0]  status
);

    localparam int unsigned STORE_BYTES = PAGE_BYTES * MAX_PAGES;
    localparam int unsigned ROWS        = (STORE_BYTES + lmls_pkg::LANES - 1) / lmls_pkg::LANES;
    localparam int unsigned RW          = $clog2(ROWS);
    localparam logic [33:0] LIMIT       = 34'(PAGE_BYTES);

    logic                pages_reg;
    logic                s1_valid_reg;
    logic                s1_load_reg;
    logic [1:0]          s1_size_log_reg;
    logic                s1_sext_reg;
    logic                s1_wide_reg;
    logic [2:0]          s1_lo_reg;
    logic [1:0]          s1_status_reg;
    logic                s1_pages_reg;
    logic                s1_size_reg;
    logic                rsp_valid_reg;
    logic [63:0]         result_value_reg;
    logic [1:0]          status_reg;

    logic [63:0]         result_next;
    logic                cmd_accept;
    logic                s1_adv;
    lmls_pkg::access_t   acc;
    logic [32:0]         ea;
    logic [33:0]         ea_end;
    logic [3:0]          nbytes;
    logic                in_bounds;
    logic                store_ok;
    logic [1:0]          status0;
    logic [RW-1:0]       row0;
    logic [2:0]          lo;

    logic [7:0]          bank_we;
    logic [RW-1:0]       bank_addr [lmls_pkg::LANES];
    logic [7:0]          bank_wdata [lmls_pkg::LANES];
    logic [63:0]         rd_all;
    logic [127:0]        rd_twice;
    logic [63:0]         raw;
    logic [63:0]         ext;

    // ---------------- stage 0: decode, bounds, RAM access ----------------
    assign s1_adv     = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall  = s1_valid_reg && !s1_adv;
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign acc       = lmls_pkg::decode(opcode);
    assign ea        = {1'b0, base_address} + {1'b0, address_offset};
    assign nbytes    = 4'd1 << acc.size_log;
    assign ea_end    = {1'b0, ea} + {30'd0, nbytes};
    assign in_bounds = pages_reg && (ea_end <= LIMIT);
    assign store_ok  = cmd_accept && acc.is_store && in_bounds;
    assign row0      = ea[RW+2:3];
    assign lo        = ea[2:0];

    always_comb
    begin
        if (acc.is_load || acc.is_store)
        begin
            status0 = in_bounds ? lmls_pkg::ST_OK : lmls_pkg::ST_TRAP;
        end
        else if (acc.is_size)
        begin
            status0 = lmls_pkg::ST_OK;
        end
        else
        begin
            status0 = lmls_pkg::ST_UNSUP;
        end
    end

    // lane b carries byte k = b - lo of the access; lanes below lo wrap to the next row
    for (genvar b = 0; b < lmls_pkg::LANES; b++)
    begin : g_lane
        logic [2:0] k;
        assign k             = 3'(b) - lo;
        assign bank_addr[b]  = row0 + ((3'(b) < lo) ? RW'(1) : RW'(0));
        assign bank_we[b]    = store_ok && ({1'b0, k} < nbytes);
        assign bank_wdata[b] = store_value[8*k +: 8];

        lmls_bank #(
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .re    (cmd_accept),
            .we    (bank_we[b]),
            .addr  (bank_addr[b]),
            .wdata (bank_wdata[b]),
            .rdata (rd_all[8*b +: 8])
        );
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg     <= 1'b1;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pages_reg <= cfg_wdata;
            end
            if (cmd_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_load_reg     <= acc.is_load && in_bounds;
            s1_size_log_reg <= acc.size_log;
            s1_sext_reg     <= acc.sext;
            s1_wide_reg     <= acc.wide;
            s1_lo_reg       <= lo;
            s1_status_reg   <= status0;
            s1_pages_reg    <= pages_reg;
            s1_size_reg     <= acc.is_size;
        end
        if (s1_adv && s1_valid_reg)
        begin
            result_value_reg <= result_next;
            status_reg       <= s1_status_reg;
        end
    end

    // ---------------- stage 1: align and extend ----------------
    assign rd_twice = {rd_all, rd_all};
    assign raw      = 64'(rd_twice >> {s1_lo_reg, 3'b000});

    always_comb
    begin
        case (s1_size_log_reg)
            2'd0:    ext = {{56{s1_sext_reg & raw[7]}},  raw[7:0]};
            2'd1:    ext = {{48{s1_sext_reg & raw[15]}}, raw[15:0]};
            2'd2:    ext = {{32{s1_sext_reg & raw[31]}}, raw[31:0]};
            default: ext = raw;
        endcase
        if (s1_load_reg)
        begin
            result_next = s1_wide_reg ? ext : {32'd0, ext[31:0]};
        end
        else if (s1_size_reg)
        begin
            result_next = {63'd0, s1_pages_reg};
        end
        else
        begin
            result_next = '0;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

`ifndef NO_ASSERTIONS
    // RAM writes only come from an accepted, in-bounds store
    a_write_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        (|bank_we) |-> (cmd_accept && acc.is_store && in_bounds))
        else $error("byte lane written without an in-bounds store");

    // never overwrite a stage-1 word that cannot move on
    a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && s1_valid_reg) |-> s1_adv)
        else $error("stage 1 overwritten while stalled");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> s1_valid_reg)
        else $error("accepted word lost before stage 1");

    a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg != lmls_pkg::ST_OK) |-> (result_value_reg == 64'd0))
        else $error("trap or unsupported word carries nonzero data");

    a_narrow_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv && s1_load_reg && !s1_wide_reg)
        |=> (result_value_reg[63:32] == 32'd0))
        else $error("32-bit load leaves high half set");
`endif

endmodule

/* dv/lmls_checker.sv */
// Response checker for the load/store unit: predicts every word and compares it on the way out.
`timescale 1ns / 100ps
module lmls_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic [4:0]  opcode,
    input  logic [31:0] base_address,
    input  logic [31:0] address_offset,
    input  logic [63:0] store_value,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [63:0] result_value,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending
);

    localparam int unsigned STORE_BYTES = lmls_pkg::PAGE_BYTES_DEF * lmls_pkg::MAX_PAGES_DEF;

    typedef struct packed {
        logic [63:0]       value;
        lmls_pkg::status_t st;
    } mem_answer_t;

    logic [7:0]  mem_image [STORE_BYTES];
    logic        pages_present;
    mem_answer_t answers_due [$];
    mem_answer_t got_answer;
    mem_answer_t due_answer;

    // Run one instruction against the local memory image and return its answer.
    function automatic mem_answer_t execute_word(input logic [4:0] op, input logic [31:0] base,
                                                 input logic [31:0] offset,
                                                 input logic [63:0] data);
        mem_answer_t     ans;
        longint unsigned ea;
        longint unsigned limit;
        int unsigned     nbytes;
        int unsigned     i;
        logic            sext;
        logic            wide;
        logic            load;
        logic            store;
        logic [63:0]     sign;
        ans.value = '0;
        ans.st    = lmls_pkg::ST_OK;
        ea        = {32'd0, base} + {32'd0, offset};
        limit     = pages_present ? longint'(lmls_pkg::PAGE_BYTES_DEF) : 64'd0;
        nbytes    = 0;
        sext      = 1'b0;
        wide      = 1'b0;
        load      = 1'b0;
        store     = 1'b0;
        case (op)
            lmls_pkg::CMD_LD_W32, lmls_pkg::CMD_LD_F32:
            begin
                load = 1'b1; nbytes = 4;
            end
            lmls_pkg::CMD_LD_D64, lmls_pkg::CMD_LD_F64:
            begin
                load = 1'b1; nbytes = 8; wide = 1'b1;
            end
            lmls_pkg::CMD_LD_B_S32:
            begin
                load = 1'b1; nbytes = 1; sext = 1'b1;
            end
            lmls_pkg::CMD_LD_B_U32:
            begin
                load = 1'b1; nbytes = 1;
            end
            lmls_pkg::CMD_LD_H_S32:
            begin
                load = 1'b1; nbytes = 2; sext = 1'b1;
            end
            lmls_pkg::CMD_LD_H_U32:
            begin
                load = 1'b1; nbytes = 2;
            end
            lmls_pkg::CMD_LD_B_S64:
            begin
                load = 1'b1; nbytes = 1; sext = 1'b1; wide = 1'b1;
            end
            lmls_pkg::CMD_LD_B_U64:
            begin
                load = 1'b1; nbytes = 1; wide = 1'b1;
            end
            lmls_pkg::CMD_LD_H_S64:
            begin
                load = 1'b1; nbytes = 2; sext = 1'b1; wide = 1'b1;
            end
            lmls_pkg::CMD_LD_H_U64:
            begin
                load = 1'b1; nbytes = 2; wide = 1'b1;
            end
            lmls_pkg::CMD_LD_W_S64:
            begin
                load = 1'b1; nbytes = 4; sext = 1'b1; wide = 1'b1;
            end
            lmls_pkg::CMD_LD_W_U64:
            begin
                load = 1'b1; nbytes = 4; wide = 1'b1;
            end
            lmls_pkg::CMD_ST_W32, lmls_pkg::CMD_ST_F32, lmls_pkg::CMD_ST_W64:
            begin
                store = 1'b1; nbytes = 4;
            end
            lmls_pkg::CMD_ST_D64, lmls_pkg::CMD_ST_F64:
            begin
                store = 1'b1; nbytes = 8;
            end
            lmls_pkg::CMD_ST_B32, lmls_pkg::CMD_ST_B64:
            begin
                store = 1'b1; nbytes = 1;
            end
            lmls_pkg::CMD_ST_H32, lmls_pkg::CMD_ST_H64:
            begin
                store = 1'b1; nbytes = 2;
            end
            lmls_pkg::CMD_MEM_SIZE:
            begin
                ans.value = {63'd0, pages_present};
            end
            default:
            begin
                ans.st = lmls_pkg::ST_UNSUP;
            end
        endcase
        if ((load || store) && ea + nbytes > limit)
        begin
            ans.st = lmls_pkg::ST_TRAP;
        end
        else if (load)
        begin
            for (i = 0; i < nbytes; i++)
                ans.value[8*i +: 8] = mem_image[ea + i];
            if (nbytes < 8)
            begin
                sign = 64'd1 << (8 * nbytes - 1);
                if (sext && (ans.value & sign) != 0)
                    ans.value = ans.value | ~((sign << 1) - 64'd1);
            end
            if (!wide)
                ans.value[63:32] = '0;
        end
        else if (store)
        begin
            for (i = 0; i < nbytes; i++)
                mem_image[ea + i] = data[8*i +: 8];
        end
        return ans;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answers_due.delete();
            pages_present = 1'b1;
            pending       = 0;
        end
        else
        begin
            // Retire the outgoing word first: it always belongs to an older command.
            if (rsp_valid && !rsp_stall)
            begin
                got_answer.value = result_value;
                got_answer.st    = lmls_pkg::status_t'(status);
                if (answers_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected word value %h status %0d",
                                 $time, result_value, status);
                end
                else
                begin
                    due_answer = answers_due.pop_front();
                    if (got_answer.value !== due_answer.value ||
                        got_answer.st !== due_answer.st)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch value exp %h got %h, status exp %0d got %0d",
                                     $time, due_answer.value, got_answer.value,
                                     due_answer.st, status);
                    end
                end
            end
            // A command taken at the same edge as a config write still sees the old page count.
            if (cmd_valid && !cmd_stall)
                answers_due.push_back(execute_word(opcode, base_address, address_offset,
                                                   store_value));
            if (cfg_we)
                pages_present = cfg_wdata;
            pending = answers_due.size();
        end
    end

endmodule

/* dv/tb.sv */
// Testbench top for the load/store unit: clock, reset, command and config stimulus, verdict.
`timescale 1ns / 100ps
module tb;

    localparam int unsigned STORE_BYTES  = lmls_pkg::PAGE_BYTES_DEF * lmls_pkg::MAX_PAGES_DEF;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 64;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [4:0]  opcode;
    logic [31:0] base_address;
    logic [31:0] address_offset;
    logic [63:0] store_value;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [63:0] result_value;
    logic [1:0]  status;

    int fail_count;
    int pending;
    int words_sent   = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit quiet_sender = 1'b0;
    bit written_map [STORE_BYTES];
    logic pages_now  = 1'b1;

    linear_memory_load_store_unit_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .opcode         (opcode),
        .base_address   (base_address),
        .address_offset (address_offset),
        .store_value    (store_value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_value   (result_value),
        .status         (status)
    );

    lmls_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .opcode         (opcode),
        .base_address   (base_address),
        .address_offset (address_offset),
        .store_value    (store_value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_value   (result_value),
        .status         (status),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_load(input logic [4:0] op);
        return op <= lmls_pkg::CMD_LD_W_U64;
    endfunction

    function automatic bit is_store(input logic [4:0] op);
        return op >= lmls_pkg::CMD_ST_W32 && op <= lmls_pkg::CMD_ST_W64;
    endfunction

    function automatic int unsigned access_bytes(input logic [4:0] op);
        case (op)
            lmls_pkg::CMD_LD_B_S32, lmls_pkg::CMD_LD_B_U32, lmls_pkg::CMD_LD_B_S64,
            lmls_pkg::CMD_LD_B_U64, lmls_pkg::CMD_ST_B32, lmls_pkg::CMD_ST_B64:
                return 1;
            lmls_pkg::CMD_LD_H_S32, lmls_pkg::CMD_LD_H_U32, lmls_pkg::CMD_LD_H_S64,
            lmls_pkg::CMD_LD_H_U64, lmls_pkg::CMD_ST_H32, lmls_pkg::CMD_ST_H64:
                return 2;
            lmls_pkg::CMD_LD_W32, lmls_pkg::CMD_LD_F32, lmls_pkg::CMD_LD_W_S64,
            lmls_pkg::CMD_LD_W_U64, lmls_pkg::CMD_ST_W32, lmls_pkg::CMD_ST_F32,
            lmls_pkg::CMD_ST_W64:
                return 4;
            lmls_pkg::CMD_LD_D64, lmls_pkg::CMD_LD_F64, lmls_pkg::CMD_ST_D64,
            lmls_pkg::CMD_ST_F64:
                return 8;
            default:
                return 0;
        endcase
    endfunction

    // True when every byte of the access has been stored before.
    function automatic bit readable(input longint unsigned ea, input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            if (!written_map[ea + i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Offer one word and hold it until accepted; valid is left high on return.
    task automatic send_word(input logic [4:0] op, input logic [31:0] base,
                             input logic [31:0] offset, input logic [63:0] data);
        while (!quiet_sender && $urandom_range(0, 99) < 22)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid      <= 1'b1;
        opcode         <= op;
        base_address   <= base;
        address_offset <= offset;
        store_value    <= data;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic issue(input logic [4:0] op, input logic [31:0] base,
                         input logic [31:0] offset, input logic [63:0] data);
        longint unsigned ea;
        int unsigned     n;
        int unsigned     i;
        ea = {32'd0, base} + {32'd0, offset};
        n  = access_bytes(op);
        if (is_store(op) && ea + n <= (pages_now ? longint'(STORE_BYTES) : 64'd0))
            for (i = 0; i < n; i++)
                written_map[ea + i] = 1'b1;
        send_word(op, base, offset, data);
    endtask

    task automatic pick_operands(output logic [31:0] base, output logic [31:0] offset);
        int unsigned region;
        int unsigned ea;
        region = $urandom_range(0, 99);
        if (region < 62)
            ea = $urandom_range(0, 63);
        else if (region < 80)
            ea = $urandom_range(STORE_BYTES - 12, STORE_BYTES - 1);
        else if (region < 85)
            ea = $urandom_range(STORE_BYTES, STORE_BYTES + 15);
        else if (region < 91)
            ea = $urandom_range(0, STORE_BYTES - 1);
        else
        begin
            base   = $urandom;
            offset = $urandom;
            return;
        end
        case ($urandom_range(0, 2))
            0:
            begin
                base   = ea;
                offset = '0;
            end
            1:
            begin
                base   = '0;
                offset = ea;
            end
            default:
            begin
                offset = $urandom_range(0, ea);
                base   = ea - offset;
            end
        endcase
    endtask

    task automatic random_item();
        logic [4:0]      op;
        logic [31:0]     base;
        logic [31:0]     offset;
        logic [63:0]     data;
        longint unsigned ea;
        longint unsigned limit;
        int unsigned     pick;
        int unsigned     tries;
        bit              blocked;
        data = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 42)
            op = 5'($urandom_range(lmls_pkg::CMD_ST_W32, lmls_pkg::CMD_ST_W64));
        else if (pick < 84)
            op = 5'($urandom_range(lmls_pkg::CMD_LD_W32, lmls_pkg::CMD_LD_W_U64));
        else if (pick < 90)
            op = lmls_pkg::CMD_MEM_SIZE;
        else if (pick < 94)
            op = 5'($urandom_range(lmls_pkg::CMD_MEM_GROW, 31));
        else
            op = 5'($urandom_range(0, 31));
        limit = pages_now ? longint'(STORE_BYTES) : 64'd0;
        tries = 0;
        // A load that stays in bounds must only touch bytes already stored.
        do
        begin
            pick_operands(base, offset);
            ea      = {32'd0, base} + {32'd0, offset};
            blocked = is_load(op) && ea + access_bytes(op) <= limit &&
                      !readable(ea, access_bytes(op));
            tries++;
        end
        while (blocked && tries < 8);
        if (blocked)
            op = 5'($urandom_range(lmls_pkg::CMD_ST_W32, lmls_pkg::CMD_ST_W64));
        issue(op, base, offset, data);
    endtask

    task automatic write_pages(input logic value);
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pages_now = value;
    endtask

    // Response side: random stalls, one long hold after 200 words are sent, one stall-free run.
    initial
    begin
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                results_seen++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && words_sent >= 200)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (results_seen >= 300 && results_seen < 420)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 99) < 22);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int i;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= 1'b0;
        cmd_valid      <= 1'b0;
        opcode         <= '0;
        base_address   <= '0;
        address_offset <= '0;
        store_value    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_pages(1'b1);
        issue(lmls_pkg::CMD_MEM_SIZE, '0, '0, '0);
        issue(lmls_pkg::CMD_MEM_GROW, '0, '0, '0);
        issue(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        // Every byte negative at 0, every width positive at 8.
        issue(lmls_pkg::CMD_ST_D64, '0, '0, 64'h8899_AABB_CCDD_EEFF);
        issue(lmls_pkg::CMD_ST_F64, 32'd4, 32'd4, 64'h7766_5544_3322_1100);
        for (i = lmls_pkg::CMD_LD_W32; i <= lmls_pkg::CMD_LD_W_U64; i++)
            issue(5'(i), '0, '0, '0);
        // Top edge of memory: last full word fits, one byte further traps.
        issue(lmls_pkg::CMD_ST_D64, '0, STORE_BYTES - 8, '1);
        issue(lmls_pkg::CMD_LD_D64, STORE_BYTES - 8, '0, '0);
        issue(lmls_pkg::CMD_LD_W32, STORE_BYTES - 3, '0, '0);
        issue(lmls_pkg::CMD_ST_B32, STORE_BYTES - 1, '0, 64'h5A);
        // Address sum carries past 32 bits and must not wrap to zero.
        issue(lmls_pkg::CMD_LD_B_U32, 32'hFFFF_FFFF, 32'd1, '0);
        issue(lmls_pkg::CMD_ST_D64, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);

        repeat (300) random_item();

        // No pages present: every access traps and memory stays intact.
        write_pages(1'b0);
        issue(lmls_pkg::CMD_MEM_SIZE, '0, '0, '0);
        issue(lmls_pkg::CMD_LD_D64, '0, '0, '0);
        issue(lmls_pkg::CMD_ST_D64, '0, '0, '1);
        repeat (80) random_item();

        write_pages(1'b1);
        issue(lmls_pkg::CMD_MEM_SIZE, '0, '0, '0);
        issue(lmls_pkg::CMD_LD_D64, '0, '0, '0);
        for (i = 0; i < 300; i++)
        begin
            quiet_sender = (i >= 100 && i < 200);
            random_item();
        end
        quiet_sender = 1'b0;

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
